// File: rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants and types for the bilinear image sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    localparam int MAX_DIM_DEF     = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_W    = 9;   // image_width / image_height register width
    localparam int COORD_W  = 20;  // signed 4.16 coordinates
    localparam int FRAC_W   = 16;
    localparam int UNIT_W   = FRAC_W + 1;  // clamped coordinate, 0 .. one
    localparam int STORE_AW = 16;
    localparam int OUT_W    = 16;

    // result slots downstream of the memory: collect, lerp, output
    localparam int CREDITS  = 3;
    localparam int CRED_W   = $clog2(CREDITS + 1);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // which of the four texels a read fetches
    typedef enum logic [1:0]
    {
        TAP_00,
        TAP_01,
        TAP_10,
        TAP_11
    } tap_t;

    typedef struct packed
    {
        logic              valid;
        tap_t              tap;
        logic [FRAC_W-1:0] tx;
        logic [FRAC_W-1:0] ty;
    } rd_tag_t;

endpackage

`default_nettype wire

// File: rtl/bis_store.sv
// ----------------------------------------------------------------------------
// bis_store
// Single-port sample memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_store #(
    parameter int SAMPLE_BITS = bis_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic                          rd_en,
    input  wire logic [bis_pkg::STORE_AW-1:0]  addr,
    input  wire logic [SAMPLE_BITS-1:0]        wr_data,
    output logic      [SAMPLE_BITS-1:0]        rd_data
);

    localparam int DEPTH = 1 << bis_pkg::STORE_AW;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        else if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/bis_filter.sv
// ----------------------------------------------------------------------------
// bis_filter
// Gathers the four texels of a query, then two horizontal lerps and one
// vertical lerp, each stage registered, ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_filter #(
    parameter int SAMPLE_BITS = bis_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [SAMPLE_BITS-1:0]      rd_data,
    input  wire bis_pkg::rd_tag_t            rd_tag,
    input  wire logic                        out_stall,
    output logic                             out_valid,
    output logic [bis_pkg::OUT_W-1:0]        sampled_value
);

    localparam int FW = bis_pkg::FRAC_W;

    // a + floor((b - a) * t / 2^16), same as the weighted sum truncated
    function automatic logic [SAMPLE_BITS-1:0] lerp(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [FW-1:0]          t
    );
        logic signed [SAMPLE_BITS:0]      diff;
        logic signed [SAMPLE_BITS+FW+1:0] prod;
        logic        [SAMPLE_BITS:0]      sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, t});
        sum  = {1'b0, a} + prod[SAMPLE_BITS+FW:FW];
        return sum[SAMPLE_BITS-1:0];
    endfunction

    // partial gather
    logic [SAMPLE_BITS-1:0] g00_reg, g01_reg, g10_reg;

    // collect stage
    logic                   c_valid_reg, c_valid_next;
    logic [SAMPLE_BITS-1:0] c00_reg, c01_reg, c10_reg, c11_reg;
    logic [FW-1:0]          c_tx_reg, c_ty_reg;

    // horizontal lerp stage
    logic                   l_valid_reg, l_valid_next;
    logic [SAMPLE_BITS-1:0] l_top_reg, l_bot_reg;
    logic [FW-1:0]          l_ty_reg;

    // output stage
    logic                   o_valid_reg, o_valid_next;
    logic [SAMPLE_BITS-1:0] o_value_reg;

    logic c_load, c_adv, l_adv, o_ready, l_ready;

    assign c_load  = rd_tag.valid && (rd_tag.tap == bis_pkg::TAP_11);
    assign o_ready = !o_valid_reg || !out_stall;
    assign l_adv   = l_valid_reg && o_ready;
    assign l_ready = !l_valid_reg || o_ready;
    assign c_adv   = c_valid_reg && l_ready;

    // the issue side holds back a query unless a slot is free, so the
    // collect stage is empty or draining whenever the last texel lands
    always_comb
    begin
        c_valid_next = c_load || (c_valid_reg && !c_adv);
        l_valid_next = c_adv || (l_valid_reg && !l_adv);
        o_valid_next = l_adv || (o_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            l_valid_reg <= l_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_tag.valid)
        begin
            case (rd_tag.tap)
                bis_pkg::TAP_00: g00_reg <= rd_data;
                bis_pkg::TAP_01: g01_reg <= rd_data;
                bis_pkg::TAP_10: g10_reg <= rd_data;
                default:
                begin
                    c00_reg  <= g00_reg;
                    c01_reg  <= g01_reg;
                    c10_reg  <= g10_reg;
                    c11_reg  <= rd_data;
                    c_tx_reg <= rd_tag.tx;
                    c_ty_reg <= rd_tag.ty;
                end
            endcase
        end
        if (c_adv)
        begin
            l_top_reg <= lerp(c00_reg, c01_reg, c_tx_reg);
            l_bot_reg <= lerp(c10_reg, c11_reg, c_tx_reg);
            l_ty_reg  <= c_ty_reg;
        end
        if (l_adv)
        begin
            o_value_reg <= lerp(l_top_reg, l_bot_reg, l_ty_reg);
        end
    end

    assign out_valid     = o_valid_reg;
    assign sampled_value = bis_pkg::OUT_W'(o_value_reg);

endmodule

`default_nettype wire

// File: rtl/bilinear_image_sampler.sv
// Query: s1, s2, issue, store read (with its tag), collect, lerp and output
// registers. Throughput: one sample write every cycle unless stalled; the
// single port of the sample memory takes the four texel reads of a query
// one per cycle. Up to 3 finished queries queue behind the output.
// Reset clears all control state and sets both dimensions to one; the
// sample store has no clearing pass and holds garbage until written.
// ----------------------------------------------------------------------------
// bilinear_image_sampler
// Bilinear texture sample over a row-major image held in a sample memory.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_sampler #(
    parameter int MAX_DIM     = bis_pkg::MAX_DIM_DEF,
    parameter int SAMPLE_BITS = bis_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_write_en,
    input  wire logic                               cfg_index,
    input  wire logic [bis_pkg::CFG_W-1:0]          cfg_data,
    // input words
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               req_type,
    input  wire logic [15:0]                        sample_index,
    input  wire logic [15:0]                        sample_data,
    input  wire logic signed [bis_pkg::COORD_W-1:0] coord_u,
    input  wire logic signed [bis_pkg::COORD_W-1:0] coord_v,
    // result words
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bis_pkg::OUT_W-1:0]               sampled_value
);

    localparam int CW    = bis_pkg::COORD_W;
    localparam int FW    = bis_pkg::FRAC_W;
    localparam int UW    = bis_pkg::UNIT_W;
    localparam int AW    = bis_pkg::STORE_AW;
    localparam int CFW   = bis_pkg::CFG_W;
    localparam int CRW   = bis_pkg::CRED_W;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CMP_W = (DIM_W > CFW) ? DIM_W : CFW;
    localparam int PX_W  = UW + IDX_W;

    localparam logic [CW-1:0] ONE_C  = CW'(1) << FW;
    localparam logic [CW:0]   ONE_CX = (CW + 1)'(1) << FW;

    function automatic logic [UW-1:0] clamp_unit(input logic [CW:0] c);
        if (c[CW])
        begin
            return '0;
        end
        else if (c[CW-1:0] > ONE_C)
        begin
            return UW'(ONE_C);
        end
        else
        begin
            return UW'(c[CW-1:0]);
        end
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFW-1:0] r);
        if (r == '0)
        begin
            return DIM_W'(1);
        end
        else if (CMP_W'(r) > CMP_W'(MAX_DIM))
        begin
            return DIM_W'(MAX_DIM);
        end
        else
        begin
            return DIM_W'(r);
        end
    endfunction

    // ---------------- configuration ----------------
    logic [CFW-1:0] cfg_width_reg, cfg_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= CFW'(1);
            cfg_height_reg <= CFW'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                bis_pkg::CFG_IDX_WIDTH:  cfg_width_reg  <= cfg_data;
                bis_pkg::CFG_IDX_HEIGHT: cfg_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [IDX_W-1:0] wm1, hm1;

    assign w_eff = eff_dim(cfg_width_reg);
    assign h_eff = eff_dim(cfg_height_reg);
    assign wm1   = IDX_W'(w_eff - 1'b1);
    assign hm1   = IDX_W'(h_eff - 1'b1);

    // ---------------- pipeline control ----------------
    logic            s1_valid_reg, s1_valid_next;
    logic            s2_valid_reg, s2_valid_next;
    logic            iss_valid_reg, iss_valid_next;
    bis_pkg::tap_t   iss_tap_reg, iss_tap_next;
    logic [CRW-1:0]  credit_reg, credit_next;
    bis_pkg::rd_tag_t rd_tag_reg, rd_tag_next;

    logic in_acc, s2_ready, s1_adv, s2_adv, iss_ready, go, done;
    logic is_query, out_take;

    // ---------------- payload ----------------
    logic             s1_type_reg;
    logic [15:0]      s1_index_reg, s1_data_reg;
    logic [UW-1:0]    s1_u_reg, s1_v_reg;

    logic             s2_type_reg;
    logic [15:0]      s2_index_reg, s2_data_reg;
    logic [IDX_W-1:0] s2_x0_reg, s2_x1_reg, s2_y0_reg, s2_y1_reg;
    logic [FW-1:0]    s2_tx_reg, s2_ty_reg;

    logic             iss_type_reg;
    logic [AW-1:0]    iss_a00_reg, iss_a01_reg, iss_a10_reg, iss_a11_reg;
    logic [15:0]      iss_data_reg;
    logic [FW-1:0]    iss_tx_reg, iss_ty_reg;

    logic [CW:0]      v_flip;
    logic [PX_W-1:0]  px, py;
    logic [IDX_W-1:0] x0, y0, x1, y1;
    logic [AW-1:0]    base0, base1;
    logic [AW-1:0]    mem_addr;
    logic             mem_we, mem_re;
    logic [SAMPLE_BITS-1:0] mem_rdata;

    assign is_query  = (iss_type_reg == bis_pkg::REQ_QUERY);
    assign go        = iss_valid_reg
                       && (!is_query || (iss_tap_reg != bis_pkg::TAP_00)
                           || (credit_reg < CRW'(bis_pkg::CREDITS)));
    assign done      = go && (!is_query || (iss_tap_reg == bis_pkg::TAP_11));
    assign iss_ready = !iss_valid_reg || done;
    assign s2_adv    = s2_valid_reg && iss_ready;
    assign s2_ready  = !s2_valid_reg || iss_ready;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign in_stall  = s1_valid_reg && !s2_ready;
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;

    always_comb
    begin
        s1_valid_next  = in_acc || (s1_valid_reg && !s1_adv);
        s2_valid_next  = s1_adv || (s2_valid_reg && !s2_adv);
        iss_valid_next = s2_adv || (iss_valid_reg && !done);

        iss_tap_next = iss_tap_reg;
        if (go && is_query)
        begin
            case (iss_tap_reg)
                bis_pkg::TAP_00: iss_tap_next = bis_pkg::TAP_01;
                bis_pkg::TAP_01: iss_tap_next = bis_pkg::TAP_10;
                bis_pkg::TAP_10: iss_tap_next = bis_pkg::TAP_11;
                default:         iss_tap_next = bis_pkg::TAP_00;
            endcase
        end

        credit_next = credit_reg;
        if (go && is_query && (iss_tap_reg == bis_pkg::TAP_00) && !out_take)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!(go && is_query && (iss_tap_reg == bis_pkg::TAP_00)) && out_take)
        begin
            credit_next = credit_reg - 1'b1;
        end

        rd_tag_next.valid = go && is_query;
        rd_tag_next.tap   = iss_tap_reg;
        rd_tag_next.tx    = iss_tx_reg;
        rd_tag_next.ty    = iss_ty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            iss_valid_reg <= 1'b0;
            iss_tap_reg   <= bis_pkg::TAP_00;
            credit_reg    <= '0;
            rd_tag_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            iss_valid_reg <= iss_valid_next;
            iss_tap_reg   <= iss_tap_next;
            credit_reg    <= credit_next;
            rd_tag_reg    <= rd_tag_next;
        end
    end

    // ---------------- datapath ----------------
    assign v_flip = ONE_CX - {coord_v[CW-1], coord_v};

    // pixel position 9.16, integer part is the left/top texel
    assign px = PX_W'(s1_u_reg) * PX_W'(wm1);
    assign py = PX_W'(s1_v_reg) * PX_W'(hm1);
    assign x0 = px[FW +: IDX_W];
    assign y0 = py[FW +: IDX_W];
    assign x1 = (x0 < wm1) ? IDX_W'(x0 + 1'b1) : wm1;
    assign y1 = (y0 < hm1) ? IDX_W'(y0 + 1'b1) : hm1;

    // row bases wrap at the store depth
    assign base0 = AW'(AW'(s2_y0_reg) * AW'(w_eff));
    assign base1 = AW'(AW'(s2_y1_reg) * AW'(w_eff));

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_type_reg  <= req_type;
            s1_index_reg <= sample_index;
            s1_data_reg  <= sample_data;
            s1_u_reg     <= clamp_unit({coord_u[CW-1], coord_u});
            s1_v_reg     <= clamp_unit(v_flip);
        end
        if (s1_adv)
        begin
            s2_type_reg  <= s1_type_reg;
            s2_index_reg <= s1_index_reg;
            s2_data_reg  <= s1_data_reg;
            s2_x0_reg    <= x0;
            s2_x1_reg    <= x1;
            s2_y0_reg    <= y0;
            s2_y1_reg    <= y1;
            s2_tx_reg    <= px[FW-1:0];
            s2_ty_reg    <= py[FW-1:0];
        end
        if (s2_adv)
        begin
            iss_type_reg <= s2_type_reg;
            iss_data_reg <= s2_data_reg;
            iss_tx_reg   <= s2_tx_reg;
            iss_ty_reg   <= s2_ty_reg;
            // a write word carries its store address in the first slot
            iss_a00_reg  <= (s2_type_reg == bis_pkg::REQ_WRITE)
                            ? AW'(s2_index_reg) : AW'(base0 + AW'(s2_x0_reg));
            iss_a01_reg  <= AW'(base0 + AW'(s2_x1_reg));
            iss_a10_reg  <= AW'(base1 + AW'(s2_x0_reg));
            iss_a11_reg  <= AW'(base1 + AW'(s2_x1_reg));
        end
    end

    always_comb
    begin
        case (iss_tap_reg)
            bis_pkg::TAP_00: mem_addr = iss_a00_reg;
            bis_pkg::TAP_01: mem_addr = iss_a01_reg;
            bis_pkg::TAP_10: mem_addr = iss_a10_reg;
            default:         mem_addr = iss_a11_reg;
        endcase
    end

    assign mem_we = iss_valid_reg && !is_query;
    assign mem_re = go && is_query;

    bis_store #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .rd_en   (mem_re),
        .addr    (mem_addr),
        .wr_data (SAMPLE_BITS'(iss_data_reg)),
        .rd_data (mem_rdata)
    );

    bis_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_data       (mem_rdata),
        .rd_tag        (rd_tag_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .sampled_value (sampled_value)
    );

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CRW'(bis_pkg::CREDITS))
        else $error("result slot count exceeds capacity");

    a_result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_reg != '0))
        else $error("result word without an outstanding query");

    a_tap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_tag_reg.valid && (rd_tag_reg.tap != bis_pkg::TAP_00))
        |-> ($past(rd_tag_reg.valid)
             && ($past(rd_tag_reg.tap) != bis_pkg::TAP_11)))
        else $error("texel reads of a query are not back to back");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("read and write on the single store port at once");

endmodule

`default_nettype wire
